>>> hdl/string_repr_escaper_unit_macros.svh
`ifndef STRING_REPR_ESCAPER_UNIT_MACROS_SVH
`define STRING_REPR_ESCAPER_UNIT_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define SRE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sre assertion failed");

// next-cycle implication, checked on clk outside reset
`define SRE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sre assertion failed");

`endif

>>> hdl/sre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sre_pkg;

    localparam int MAX_LEN_DEFAULT = 62;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_A  = 8'h61;

    localparam logic [2:0] CNT_ONE  = 3'd1;
    localparam logic [2:0] CNT_TWO  = 3'd2;
    localparam logic [2:0] CNT_FOUR = 3'd4;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_OPEN,
        ST_BODY,
        ST_CLOSE
    } sre_state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'd0, nib};
        if (nib < 4'd10)
        begin
            return CH_ZERO + ext;
        end
        return CH_LOW_A + ext - 8'd10;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sre_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sre_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

interface sre_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_chars;
    logic [2:0]  out_count;
    logic        out_last;
    logic        overflow;

    modport source (output valid, output out_chars, output out_count, output out_last,
                    output overflow, input ready);
    modport sink   (input valid, input out_chars, input out_count, input out_last,
                    input overflow, output ready);
endinterface

`default_nettype wire

>>> hdl/sre_store.sv
`timescale 1ns / 1ps
`default_nettype none

module sre_store #(
    parameter int DEPTH = sre_pkg::MAX_LEN_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/sre_encode.sv
`timescale 1ns / 1ps
`default_nettype none

module sre_encode (
    input  wire logic [7:0]  data,
    input  wire logic        quote_dq,
    output logic      [31:0] chars,
    output logic      [2:0]  count
);

    logic [7:0] quote;

    assign quote = quote_dq ? sre_pkg::CH_DQUOTE : sre_pkg::CH_SQUOTE;

    always_comb
    begin
        chars = {24'd0, data};
        count = sre_pkg::CNT_ONE;
        if (data == quote || data == sre_pkg::CH_BSLASH)
        begin
            chars = {16'd0, data, sre_pkg::CH_BSLASH};
            count = sre_pkg::CNT_TWO;
        end
        else if (data == sre_pkg::CH_TAB)
        begin
            chars = {16'd0, sre_pkg::CH_LOW_T, sre_pkg::CH_BSLASH};
            count = sre_pkg::CNT_TWO;
        end
        else if (data == sre_pkg::CH_LF)
        begin
            chars = {16'd0, sre_pkg::CH_LOW_N, sre_pkg::CH_BSLASH};
            count = sre_pkg::CNT_TWO;
        end
        else if (data == sre_pkg::CH_CR)
        begin
            chars = {16'd0, sre_pkg::CH_LOW_R, sre_pkg::CH_BSLASH};
            count = sre_pkg::CNT_TWO;
        end
        else if (data < sre_pkg::CH_SPACE || data >= sre_pkg::CH_DEL)
        begin
            chars = {sre_pkg::hex_char(data[3:0]), sre_pkg::hex_char(data[7:4]),
                     sre_pkg::CH_LOW_X, sre_pkg::CH_BSLASH};
            count = sre_pkg::CNT_FOUR;
        end
    end

endmodule

`default_nettype wire

>>> hdl/string_repr_escaper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | role   | word
// bytes    | sink   | data_byte, has_byte, last
// escaped  | source | out_chars, out_count, out_last, overflow
//
// loading takes one word per cycle; an accepted byte is written to the store if it has room
// after the last word, output runs one escape unit per cycle while not stalled: open quote,
// one unit per stored byte, close quote, so fill + 2 results in all
// the store read is registered and is issued ahead of each unit
// rst_n clears the fill count, quote flags, drop flag and the sequencer
// a stalled output holds the sequencer and the pending store read

`include "string_repr_escaper_unit_macros.svh"

module string_repr_escaper_unit #(
    parameter int MAX_LEN = sre_pkg::MAX_LEN_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    sre_in_if.sink    bytes,
    sre_out_if.source escaped
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

    sre_pkg::sre_state_t state_reg, state_next;

    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          saw_sq_reg, saw_sq_next;
    logic          saw_dq_reg, saw_dq_next;
    logic          drop_reg, drop_next;

    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_chars_reg, out_chars_next;
    logic [2:0]    out_count_reg, out_count_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          accept;
    logic          slot_free;
    logic          store_byte;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          quote_dq;
    logic [7:0]    quote;
    logic [31:0]   enc_chars;
    logic [2:0]    enc_count;
    logic [CW-1:0] idx_inc;

    assign accept     = bytes.valid && bytes.ready;
    assign slot_free  = !out_valid_reg || escaped.ready;
    assign store_byte = accept && bytes.has_byte && (fill_reg < FULL);
    assign wr_en      = store_byte;
    assign quote_dq   = saw_sq_reg && !saw_dq_reg;
    assign quote      = quote_dq ? sre_pkg::CH_DQUOTE : sre_pkg::CH_SQUOTE;
    assign idx_inc    = idx_reg + CW'(1);

    sre_store #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (bytes.data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sre_encode u_encode (
        .data     (rd_data),
        .quote_dq (quote_dq),
        .chars    (enc_chars),
        .count    (enc_count)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sre_pkg::ST_LOAD:
            begin
                if (accept && bytes.last)
                begin
                    state_next = sre_pkg::ST_OPEN;
                end
            end
            sre_pkg::ST_OPEN:
            begin
                if (slot_free)
                begin
                    state_next = (fill_reg == '0) ? sre_pkg::ST_CLOSE : sre_pkg::ST_BODY;
                end
            end
            sre_pkg::ST_BODY:
            begin
                if (slot_free && idx_inc == fill_reg)
                begin
                    state_next = sre_pkg::ST_CLOSE;
                end
            end
            sre_pkg::ST_CLOSE:
            begin
                if (slot_free)
                begin
                    state_next = sre_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = sre_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        bytes.ready    = 1'b0;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        saw_sq_next    = saw_sq_reg;
        saw_dq_next    = saw_dq_reg;
        drop_next      = drop_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        out_valid_next = out_valid_reg && !escaped.ready;
        out_chars_next = out_chars_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        case (state_reg)
            sre_pkg::ST_LOAD:
            begin
                bytes.ready = 1'b1;
                if (store_byte)
                begin
                    fill_next = fill_reg + CW'(1);
                    if (bytes.data_byte == sre_pkg::CH_SQUOTE)
                    begin
                        saw_sq_next = 1'b1;
                    end
                    if (bytes.data_byte == sre_pkg::CH_DQUOTE)
                    begin
                        saw_dq_next = 1'b1;
                    end
                end
                else if (accept && bytes.has_byte)
                begin
                    drop_next = 1'b1;
                end
            end
            sre_pkg::ST_OPEN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_chars_next = {24'd0, quote};
                    out_count_next = sre_pkg::CNT_ONE;
                    out_last_next  = 1'b0;
                    out_ovf_next   = drop_reg;
                    idx_next       = '0;
                    rd_en          = (fill_reg != '0);
                    rd_addr        = '0;
                end
            end
            sre_pkg::ST_BODY:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_chars_next = enc_chars;
                    out_count_next = enc_count;
                    out_last_next  = 1'b0;
                    out_ovf_next   = drop_reg;
                    idx_next       = idx_inc;
                    rd_en          = (idx_inc != fill_reg);
                    rd_addr        = idx_inc[AW-1:0];
                end
            end
            sre_pkg::ST_CLOSE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_chars_next = {24'd0, quote};
                    out_count_next = sre_pkg::CNT_ONE;
                    out_last_next  = 1'b1;
                    out_ovf_next   = drop_reg;
                    fill_next      = '0;
                    saw_sq_next    = 1'b0;
                    saw_dq_next    = 1'b0;
                    drop_next      = 1'b0;
                end
            end
            default:
            begin
                bytes.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sre_pkg::ST_LOAD;
            fill_reg      <= '0;
            idx_reg       <= '0;
            saw_sq_reg    <= 1'b0;
            saw_dq_reg    <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            saw_sq_reg    <= saw_sq_next;
            saw_dq_reg    <= saw_dq_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_chars_reg <= out_chars_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign escaped.valid     = out_valid_reg;
    assign escaped.out_chars = out_chars_reg;
    assign escaped.out_count = out_count_reg;
    assign escaped.out_last  = out_last_reg;
    assign escaped.overflow  = out_ovf_reg;

    `SRE_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FULL)
    `SRE_ASSERT_NOW(a_drop_full, drop_reg, fill_reg == FULL)
    `SRE_ASSERT_NOW(a_body_index, state_reg == sre_pkg::ST_BODY, idx_reg < fill_reg)
    `SRE_ASSERT_NEXT(a_last_opens, accept && bytes.last, state_reg == sre_pkg::ST_OPEN)

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int STORE_DEPTH = sre_pkg::MAX_LEN_DEFAULT;
    localparam int ITEM_TARGET = 330;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE      = 80;

    typedef struct packed {
        logic [31:0] chars;
        logic [2:0]  count;
        logic        fin;
        logic        ovf;
    } esc_unit_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        h;
        logic        l;
        logic [6:0]  reps;
        logic        typed;
        logic [31:0] t_chars;
        logic [2:0]  t_count;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sre_in_if  byte_chan ();
    sre_out_if esc_chan ();

    string_repr_escaper_unit i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_chan),
        .escaped (esc_chan)
    );

    // predictor state
    logic [7:0] held_bytes [STORE_DEPTH];
    int         held_count;
    bit         seen_sq;
    bit         seen_dq;
    bit         lost_bytes;
    esc_unit_t  pending_units [$];

    int mismatch_count;
    int item_total;
    bit steady;
    bit hold_req;

    stim_row_t script [25];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #3_000_000;
        $display("string_repr_escaper_unit verification failed");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int gap_draw();
        if (steady)
        begin
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic logic [7:0] nib_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h61 + {4'd0, n} - 8'd10);
    endfunction

    function automatic esc_unit_t escape_byte(input logic [7:0] c, input logic [7:0] q);
        esc_unit_t u;
        u.fin = 1'b0;
        u.ovf = lost_bytes;
        if (c == q || c == sre_pkg::CH_BSLASH)
        begin
            u.chars = {16'd0, c, sre_pkg::CH_BSLASH};
            u.count = sre_pkg::CNT_TWO;
        end
        else if (c == sre_pkg::CH_TAB)
        begin
            u.chars = {16'd0, sre_pkg::CH_LOW_T, sre_pkg::CH_BSLASH};
            u.count = sre_pkg::CNT_TWO;
        end
        else if (c == sre_pkg::CH_LF)
        begin
            u.chars = {16'd0, sre_pkg::CH_LOW_N, sre_pkg::CH_BSLASH};
            u.count = sre_pkg::CNT_TWO;
        end
        else if (c == sre_pkg::CH_CR)
        begin
            u.chars = {16'd0, sre_pkg::CH_LOW_R, sre_pkg::CH_BSLASH};
            u.count = sre_pkg::CNT_TWO;
        end
        else if (c < sre_pkg::CH_SPACE || c >= sre_pkg::CH_DEL)
        begin
            u.chars = {nib_char(c[3:0]), nib_char(c[7:4]), sre_pkg::CH_LOW_X,
                       sre_pkg::CH_BSLASH};
            u.count = sre_pkg::CNT_FOUR;
        end
        else
        begin
            u.chars = {24'd0, c};
            u.count = sre_pkg::CNT_ONE;
        end
        return u;
    endfunction

    task automatic absorb_word(input logic [7:0] b, input logic h, input logic l);
        logic [7:0] q;
        esc_unit_t  u;
        if (h)
        begin
            if (held_count < STORE_DEPTH)
            begin
                held_bytes[held_count] = b;
                held_count++;
                if (b == sre_pkg::CH_SQUOTE)
                begin
                    seen_sq = 1'b1;
                end
                if (b == sre_pkg::CH_DQUOTE)
                begin
                    seen_dq = 1'b1;
                end
            end
            else
            begin
                lost_bytes = 1'b1;
            end
        end
        if (!l)
        begin
            return;
        end
        q = (seen_sq && !seen_dq) ? sre_pkg::CH_DQUOTE : sre_pkg::CH_SQUOTE;
        u = '{chars: {24'd0, q}, count: sre_pkg::CNT_ONE, fin: 1'b0, ovf: lost_bytes};
        pending_units.push_back(u);
        for (int i = 0; i < held_count; i++)
        begin
            pending_units.push_back(escape_byte(held_bytes[i], q));
        end
        u.fin = 1'b1;
        pending_units.push_back(u);
        held_count = 0;
        seen_sq    = 1'b0;
        seen_dq    = 1'b0;
        lost_bytes = 1'b0;
    endtask

    task automatic put_word(input logic [7:0] b, input logic h, input logic l,
                            input logic typed, input logic [31:0] t_chars,
                            input logic [2:0] t_count);
        int        gap;
        int        idx;
        esc_unit_t u;
        gap = gap_draw();
        if (gap > 0)
        begin
            @(negedge clk);
            byte_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_chan.valid     <= 1'b1;
        byte_chan.data_byte <= b;
        byte_chan.has_byte  <= h;
        byte_chan.last      <= l;
        do @(posedge clk); while (!byte_chan.ready);
        absorb_word(b, h, l);
        item_total++;
        // hand-typed unit for the final byte of the string
        if (typed)
        begin
            idx       = pending_units.size() - 2;
            u         = pending_units[idx];
            u.chars   = t_chars;
            u.count   = t_count;
            pending_units[idx] = u;
        end
    endtask

    task automatic idle_sender();
        @(negedge clk);
        byte_chan.valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? sre_pkg::CH_SQUOTE : sre_pkg::CH_DQUOTE;
            1: return sre_pkg::CH_BSLASH;
            2: return 8'($urandom_range(0, 31));
            3: return 8'($urandom_range(127, 255));
            4:
            begin
                case ($urandom_range(0, 2))
                    0: return sre_pkg::CH_TAB;
                    1: return sre_pkg::CH_LF;
                    default: return sre_pkg::CH_CR;
                endcase
            end
            5: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    task automatic send_random_string();
        int   len;
        int   r;
        logic tail_byte;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            len = $urandom_range(0, 8);
        end
        else if (r < 92)
        begin
            len = $urandom_range(9, 40);
        end
        else
        begin
            len = $urandom_range(58, 70);
        end
        tail_byte = (len > 0) && ($urandom_range(0, 1) != 0);
        for (int k = 0; k < len; k++)
        begin
            // stray word without a byte
            if ($urandom_range(0, 99) < 6)
            begin
                put_word(8'($urandom), 1'b0, 1'b0, 1'b0, 32'd0, 3'd0);
            end
            put_word(pick_byte(), 1'b1, tail_byte && (k == len - 1), 1'b0, 32'd0, 3'd0);
        end
        if (!tail_byte)
        begin
            put_word(8'($urandom), 1'b0, 1'b1, 1'b0, 32'd0, 3'd0);
        end
    endtask

    // result side
    initial
    begin
        int        stall;
        esc_unit_t got;
        esc_unit_t want;
        esc_chan.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                @(negedge clk);
                esc_chan.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            stall = gap_draw();
            if (stall > 0)
            begin
                @(negedge clk);
                esc_chan.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            esc_chan.ready <= 1'b1;
            do @(posedge clk); while (!esc_chan.valid);
            got = '{chars: esc_chan.out_chars, count: esc_chan.out_count,
                    fin: esc_chan.out_last, ovf: esc_chan.overflow};
            if (pending_units.size() == 0)
            begin
                flag_mismatch("unexpected word", got.chars, 32'd0);
            end
            else
            begin
                want = pending_units.pop_front();
                if (got.chars !== want.chars)
                begin
                    flag_mismatch("out_chars", got.chars, want.chars);
                end
                if (got.count !== want.count)
                begin
                    flag_mismatch("out_count", 32'(got.count), 32'(want.count));
                end
                if (got.fin !== want.fin)
                begin
                    flag_mismatch("out_last", 32'(got.fin), 32'(want.fin));
                end
                if (got.ovf !== want.ovf)
                begin
                    flag_mismatch("overflow", 32'(got.ovf), 32'(want.ovf));
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int  strings_sent;
        bit  drained;
        logic last_rep;
        mismatch_count = 0;
        item_total     = 0;
        steady         = 1'b0;
        hold_req       = 1'b0;
        held_count     = 0;
        seen_sq        = 1'b0;
        seen_dq        = 1'b0;
        lost_bytes     = 1'b0;
        strings_sent   = 0;
        drained        = 1'b0;

        rst_n               = 1'b0;
        byte_chan.valid     = 1'b0;
        byte_chan.data_byte = 8'd0;
        byte_chan.has_byte  = 1'b0;
        byte_chan.last      = 1'b0;

        script = '{
            '{8'h00,              1'b0, 1'b1, 7'd1,  1'b0, 32'h0,
              3'd0},
            '{8'h00,              1'b1, 1'b1, 7'd1,  1'b1, 32'h3030785c,
              sre_pkg::CNT_FOUR},
            '{8'hff,              1'b1, 1'b1, 7'd1,  1'b1, 32'h6666785c,
              sre_pkg::CNT_FOUR},
            '{sre_pkg::CH_DEL,    1'b1, 1'b1, 7'd1,  1'b1, 32'h6637785c,
              sre_pkg::CNT_FOUR},
            '{8'h1f,              1'b1, 1'b1, 7'd1,  1'b1, 32'h6631785c,
              sre_pkg::CNT_FOUR},
            '{sre_pkg::CH_SPACE,  1'b1, 1'b1, 7'd1,  1'b1, 32'h00000020,
              sre_pkg::CNT_ONE},
            '{8'h7e,              1'b1, 1'b1, 7'd1,  1'b1, 32'h0000007e,
              sre_pkg::CNT_ONE},
            '{sre_pkg::CH_TAB,    1'b1, 1'b1, 7'd1,  1'b1, 32'h0000745c,
              sre_pkg::CNT_TWO},
            '{sre_pkg::CH_LF,     1'b1, 1'b1, 7'd1,  1'b1, 32'h00006e5c,
              sre_pkg::CNT_TWO},
            '{sre_pkg::CH_CR,     1'b1, 1'b1, 7'd1,  1'b1, 32'h0000725c,
              sre_pkg::CNT_TWO},
            '{sre_pkg::CH_BSLASH, 1'b1, 1'b1, 7'd1,  1'b1, 32'h00005c5c,
              sre_pkg::CNT_TWO},
            '{sre_pkg::CH_SQUOTE, 1'b1, 1'b1, 7'd1,  1'b1, 32'h00000027,
              sre_pkg::CNT_ONE},
            '{sre_pkg::CH_DQUOTE, 1'b1, 1'b1, 7'd1,  1'b1, 32'h00000022,
              sre_pkg::CNT_ONE},
            '{sre_pkg::CH_SQUOTE, 1'b1, 1'b0, 7'd1,  1'b0, 32'h0,
              3'd0},
            '{sre_pkg::CH_DQUOTE, 1'b1, 1'b1, 7'd1,  1'b1, 32'h00000022,
              sre_pkg::CNT_ONE},
            '{8'h41,              1'b1, 1'b0, 7'd1,  1'b0, 32'h0,
              3'd0},
            '{8'ha5,              1'b0, 1'b0, 7'd1,  1'b0, 32'h0,
              3'd0},
            '{8'h42,              1'b1, 1'b0, 7'd1,  1'b0, 32'h0,
              3'd0},
            '{8'h5a,              1'b0, 1'b1, 7'd1,  1'b0, 32'h0,
              3'd0},
            '{sre_pkg::CH_SQUOTE, 1'b1, 1'b0, 7'd62, 1'b0, 32'h0,
              3'd0},
            '{sre_pkg::CH_DQUOTE, 1'b1, 1'b1, 7'd1,  1'b0, 32'h0,
              3'd0},
            '{8'h61,              1'b1, 1'b0, 7'd61, 1'b0, 32'h0,
              3'd0},
            '{8'h80,              1'b1, 1'b1, 7'd1,  1'b1, 32'h3038785c,
              sre_pkg::CNT_FOUR},
            '{8'h7a,              1'b1, 1'b0, 7'd65, 1'b0, 32'h0,
              3'd0},
            '{8'h00,              1'b0, 1'b1, 7'd1,  1'b0, 32'h0,
              3'd0}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed strings
        foreach (script[r])
        begin
            for (int k = 0; k < int'(script[r].reps); k++)
            begin
                last_rep = (k == int'(script[r].reps) - 1);
                put_word(script[r].b, script[r].h, script[r].l && last_rep,
                         script[r].typed && last_rep, script[r].t_chars, script[r].t_count);
            end
        end

        // random strings
        while (item_total < ITEM_TARGET)
        begin
            if (strings_sent == 3)
            begin
                hold_req = 1'b1;
            end
            if (!drained && item_total >= 250)
            begin
                drained = 1'b1;
                idle_sender();
                while (pending_units.size() != 0) @(posedge clk);
            end
            steady = (item_total >= 280 && item_total < 310);
            send_random_string();
            strings_sent++;
        end
        steady = 1'b0;
        idle_sender();

        while (pending_units.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("string_repr_escaper_unit verification clean");
        end
        else
        begin
            $display("string_repr_escaper_unit verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/sre_pkg.sv
hdl/sre_if.sv
hdl/sre_store.sv
hdl/sre_encode.sv
hdl/string_repr_escaper_unit.sv
bench/tb.sv
